/* hw/rtl/tfb_pkg.sv */
// shared constants, codes and helpers of the telemetry frame builder
`default_nettype none

package tfb_pkg;

    // field and register widths
    localparam int SCALE_W       = 14;
    localparam int SAMPLE_W      = 32;
    localparam int VALUE_W       = 16;
    localparam int NUM_SAMPLES   = 6;
    localparam int FRAC_BITS_DEF = 16;

    // frame bytes
    localparam logic [7:0] HDR0    = 8'hAA;
    localparam logic [7:0] HDR1    = 8'hFF;
    localparam logic [7:0] ID_SIX  = 8'h01;
    localparam logic [7:0] ID_ATT  = 8'h03;
    localparam logic [7:0] ID_QUAT = 8'h04;

    // request kind codes
    localparam logic [1:0] OP_SIX  = 2'd0;
    localparam logic [1:0] OP_ATT  = 2'd1;
    localparam logic [1:0] OP_QUAT = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // register indexes
    localparam logic [1:0] REG_MOTION = 2'd0;
    localparam logic [1:0] REG_ANGLE  = 2'd1;
    localparam logic [1:0] REG_QUAT   = 2'd2;
    localparam logic [1:0] REG_STATUS = 2'd3;

    // register reset values
    localparam logic [SCALE_W-1:0] MOTION_RST = SCALE_W'(1000);
    localparam logic [SCALE_W-1:0] ANGLE_RST  = SCALE_W'(100);
    localparam logic [SCALE_W-1:0] QUAT_RST   = SCALE_W'(1);
    localparam logic [7:0]         STATUS_RST = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // two's complement magnitude, fits 32 bits even for the most negative value
    function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
        magnitude = v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/telemetry_frame_builder.sv */
// telemetry frame builder: bit-serial scaling of samples and byte-wise frame output
//
//  channel   direction  handshake                  word
//  request   in         i_valid / o_stall          i_op, i_sample_0 .. i_sample_5
//  frame     out        o_valid / i_stall          o_out_byte, o_frame_end
//  config    in         psel penable pwrite pready paddr, pwdata, prdata
//
//  a request is scaled value by value and then sent as a frame of 2*N+7 bytes, N values per kind
//  (six-axis 6, attitude 3, quaternion 4)
//  the shift-add multiplier retires one scale bit per cycle, 14 bits plus a finish step
//  per value; bytes then leave at one per cycle from the output register unless stalled
//  reset (synchronous, active low) returns the sequencer to idle and reloads the registers
//  an output stall holds the byte in the output register; the next request is taken
//  while the final byte of a frame still waits
`default_nettype none

module telemetry_frame_builder #(
    parameter int FRAC_BITS = tfb_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // request channel
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [1:0]                          i_op,
    input  wire  signed [tfb_pkg::SAMPLE_W-1:0] i_sample_0,
    input  wire  signed [tfb_pkg::SAMPLE_W-1:0] i_sample_1,
    input  wire  signed [tfb_pkg::SAMPLE_W-1:0] i_sample_2,
    input  wire  signed [tfb_pkg::SAMPLE_W-1:0] i_sample_3,
    input  wire  signed [tfb_pkg::SAMPLE_W-1:0] i_sample_4,
    input  wire  signed [tfb_pkg::SAMPLE_W-1:0] i_sample_5,
    // frame channel
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [7:0]                          o_out_byte,
    output logic                                o_frame_end,
    // configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [3:0]                          paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int SCALE_W = tfb_pkg::SCALE_W;
    localparam int SMP_W   = tfb_pkg::SAMPLE_W;
    localparam int VAL_W   = tfb_pkg::VALUE_W;
    localparam int ACC_W   = SMP_W + SCALE_W;
    localparam int STEP_W  = $clog2(SCALE_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SCALE_W);

    // configuration registers
    logic [SCALE_W-1:0] r_motion_scale;
    logic [SCALE_W-1:0] r_angle_scale;
    logic [SCALE_W-1:0] r_quat_scale;
    logic [7:0]         r_status_byte;

    // sequencer
    tfb_pkg::t_state r_state;

    // request context
    logic [2:0]         r_count;
    logic               r_little;
    logic [7:0]         r_id;
    logic [SCALE_W-1:0] r_scale;

    // serial multiplier
    logic [SMP_W-1:0]   r_samp [tfb_pkg::NUM_SAMPLES-1];
    logic [SMP_W-1:0]   r_mag;
    logic               r_neg;
    logic [SCALE_W-1:0] r_sc;
    logic [ACC_W-1:0]   r_acc;
    logic [STEP_W-1:0]  r_step;
    logic [2:0]         r_vidx;
    logic [VAL_W-1:0]   r_held [tfb_pkg::NUM_SAMPLES];

    // emission
    logic [4:0] r_byte;
    logic [7:0] r_sum;
    logic [7:0] r_add;
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_end;

    // apb
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_scale <= tfb_pkg::MOTION_RST;
            r_angle_scale  <= tfb_pkg::ANGLE_RST;
            r_quat_scale   <= tfb_pkg::QUAT_RST;
            r_status_byte  <= tfb_pkg::STATUS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tfb_pkg::REG_MOTION: r_motion_scale <= pwdata[SCALE_W-1:0];
                tfb_pkg::REG_ANGLE:  r_angle_scale  <= pwdata[SCALE_W-1:0];
                tfb_pkg::REG_QUAT:   r_quat_scale   <= pwdata[SCALE_W-1:0];
                tfb_pkg::REG_STATUS: r_status_byte  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            tfb_pkg::REG_MOTION: prdata = {{(32-SCALE_W){1'b0}}, r_motion_scale};
            tfb_pkg::REG_ANGLE:  prdata = {{(32-SCALE_W){1'b0}}, r_angle_scale};
            tfb_pkg::REG_QUAT:   prdata = {{(32-SCALE_W){1'b0}}, r_quat_scale};
            tfb_pkg::REG_STATUS: prdata = {24'd0, r_status_byte};
            default:             prdata = '0;
        endcase
    end

    // kind decode of the incoming request
    logic               d_known;
    logic [2:0]         d_count;
    logic               d_little;
    logic [7:0]         d_id;
    logic [SCALE_W-1:0] d_scale;

    always_comb begin
        d_known  = 1'b1;
        d_count  = 3'd6;
        d_little = 1'b0;
        d_id     = tfb_pkg::ID_SIX;
        d_scale  = r_motion_scale;
        unique case (i_op)
            tfb_pkg::OP_SIX: begin
                d_count = 3'd6;
                d_id    = tfb_pkg::ID_SIX;
                d_scale = r_motion_scale;
            end
            tfb_pkg::OP_ATT: begin
                d_count  = 3'd3;
                d_little = 1'b1;
                d_id     = tfb_pkg::ID_ATT;
                d_scale  = r_angle_scale;
            end
            tfb_pkg::OP_QUAT: begin
                d_count = 3'd4;
                d_id    = tfb_pkg::ID_QUAT;
                d_scale = r_quat_scale;
            end
            default: d_known = 1'b0;   // undefined kind, request dropped
        endcase
    end

    logic in_acc;
    assign o_stall = (r_state != tfb_pkg::S_IDLE);
    assign in_acc  = i_valid && !o_stall;

    // truncate toward zero and saturate the finished product
    logic             sat_big;
    logic [14:0]      sat_mag;
    logic [VAL_W-1:0] sat_val;

    always_comb begin
        sat_big = |r_acc[ACC_W-1:FRAC_BITS+15];
        sat_mag = r_acc[FRAC_BITS+14:FRAC_BITS];
        if (r_neg) begin
            sat_val = sat_big ? 16'h8000 : (16'd0 - {1'b0, sat_mag});
        end else begin
            sat_val = sat_big ? 16'h7FFF : {1'b0, sat_mag};
        end
    end

    // frame byte at the current position
    logic [4:0] stat_pos;
    logic [4:0] sum_pos;
    logic [4:0] pay_j;
    logic [7:0] e_byte;
    logic       e_end;
    logic [VAL_W-1:0] e_word;

    always_comb begin
        stat_pos = {1'b0, r_count, 1'b0} + 5'd4;
        sum_pos  = stat_pos + 5'd1;
        pay_j    = r_byte - 5'd4;
        e_end    = 1'b0;
        e_word   = '0;
        if (r_byte == 5'd0) begin
            e_byte = tfb_pkg::HDR0;
        end else if (r_byte == 5'd1) begin
            e_byte = tfb_pkg::HDR1;
        end else if (r_byte == 5'd2) begin
            e_byte = r_id;
        end else if (r_byte == 5'd3) begin
            e_byte = {4'd0, r_count, 1'b1};   // payload plus status length
        end else if (r_byte < stat_pos) begin
            e_word = r_held[pay_j[3:1]];
            e_byte = (pay_j[0] == r_little) ? e_word[15:8] : e_word[7:0];
        end else if (r_byte == stat_pos) begin
            e_byte = r_status_byte;
        end else if (r_byte == sum_pos) begin
            e_byte = r_sum;
        end else begin
            e_byte = r_add;
            e_end  = 1'b1;
        end
    end

    logic ld;
    assign ld = (r_state == tfb_pkg::S_EMIT) && (!r_o_valid || !i_stall);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tfb_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_step    <= '0;
            r_vidx    <= '0;
            r_byte    <= '0;
        end else begin
            if (ld) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                tfb_pkg::S_IDLE: begin
                    if (in_acc && d_known) begin
                        r_state <= tfb_pkg::S_MUL;
                        r_step  <= '0;
                        r_vidx  <= '0;
                    end
                end
                tfb_pkg::S_MUL: begin
                    if (r_step != STEP_LAST) begin
                        r_step <= r_step + STEP_W'(1);
                    end else begin
                        r_step <= '0;
                        if (r_vidx == r_count - 3'd1) begin
                            r_state <= tfb_pkg::S_EMIT;
                            r_byte  <= '0;
                        end else begin
                            r_vidx <= r_vidx + 3'd1;
                        end
                    end
                end
                tfb_pkg::S_EMIT: begin
                    if (ld) begin
                        r_byte <= r_byte + 5'd1;
                        if (e_end) begin
                            r_state <= tfb_pkg::S_IDLE;
                        end
                    end
                end
                default: r_state <= tfb_pkg::S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc && d_known) begin
            r_count  <= d_count;
            r_little <= d_little;
            r_id     <= d_id;
            r_scale  <= d_scale;
            r_sc     <= d_scale;
            r_acc    <= '0;
            r_mag    <= tfb_pkg::magnitude(i_sample_0);
            r_neg    <= i_sample_0[SMP_W-1];
            r_samp[0] <= i_sample_1;
            r_samp[1] <= i_sample_2;
            r_samp[2] <= i_sample_3;
            r_samp[3] <= i_sample_4;
            r_samp[4] <= i_sample_5;
        end else if (r_state == tfb_pkg::S_MUL) begin
            if (r_step != STEP_LAST) begin
                // msb-first shift-add, one scale bit a cycle
                r_acc <= {r_acc[ACC_W-2:0], 1'b0}
                       + (r_sc[SCALE_W-1] ? {{SCALE_W{1'b0}}, r_mag} : '0);
                r_sc  <= {r_sc[SCALE_W-2:0], 1'b0};
            end else begin
                r_held[r_vidx] <= sat_val;
                r_acc <= '0;
                r_sc  <= r_scale;
                r_mag <= tfb_pkg::magnitude(r_samp[0]);
                r_neg <= r_samp[0][SMP_W-1];
                for (int k = 0; k < tfb_pkg::NUM_SAMPLES - 2; k++) begin
                    r_samp[k] <= r_samp[k+1];
                end
            end
        end
        if (r_state == tfb_pkg::S_MUL) begin
            r_sum <= '0;
            r_add <= '0;
        end else if (ld && (r_byte < sum_pos)) begin
            r_sum <= r_sum + e_byte;
            r_add <= r_add + r_sum + e_byte;
        end
        if (ld) begin
            r_o_byte <= e_byte;
            r_o_end  <= e_end;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_frame_end = r_o_end && r_o_valid;

    // checks
    a_end_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_end |-> o_valid)
        else $error("frame end flagged without a valid byte");

    a_start_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op != tfb_pkg::OP_NONE)) |=> (r_state == tfb_pkg::S_MUL))
        else $error("known request did not start scaling");

    a_none_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op == tfb_pkg::OP_NONE)) |=> (r_state == tfb_pkg::S_IDLE))
        else $error("undefined kind started a frame");

    a_vidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfb_pkg::S_MUL) |-> (r_vidx < r_count))
        else $error("value index beyond the kind's count");

    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfb_pkg::S_EMIT) |-> (r_byte <= sum_pos + 5'd1))
        else $error("byte position beyond the frame");

endmodule

`default_nettype wire
